/* design/dmrw_pkg.sv */
// ----------------------------------------------------------------------------
// dmrw_pkg
// Types and constants shared by the DNS message record walker modules.
// ----------------------------------------------------------------------------
package dmrw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  section;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] rdata_length;
    logic [11:0] name_length;
    logic [11:0] record_offset;
    logic        is_query;
    logic        is_truncated;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic rec_vld;
    logic frm_vld;
  } wr_ctl_t;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_LABEL   = 3'd2;
  localparam logic [2:0] PH_POINTER = 3'd3;
  localparam logic [2:0] PH_FIXED   = 3'd4;
  localparam logic [2:0] PH_RDATA   = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_HALT    = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EARLY   = 2'd1;
  localparam logic [1:0] ST_RECLIM  = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  localparam logic [15:0] FLAG_RESPONSE = 16'h8000;
  localparam logic [15:0] FLAG_TRUNC    = 16'h0200;
  localparam int          HDR_BYTES     = 12;
  localparam logic [3:0]  RR_FIXED      = 4'd10;
  localparam logic [3:0]  Q_FIXED       = 4'd4;

endpackage

/* design/dmrw_parser.sv */
// ----------------------------------------------------------------------------
// dmrw_parser
// Front end: walks header, names, fixed parts and rdata one byte per cycle while take is high.
// ----------------------------------------------------------------------------
module dmrw_parser #(
  parameter int MAX_FRAME_BYTES = 4096,
  parameter int MAX_RECORDS     = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  dmrw_pkg::in_item_t  item,
  output dmrw_pkg::wr_ctl_t   wr,
  output dmrw_pkg::out_item_t rec,
  output dmrw_pkg::out_item_t frm
);
  import dmrw_pkg::*;

  localparam int BPW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int RSW = $clog2(MAX_RECORDS + 1);

  logic [BPW-1:0] bp_r, bp_nxt;
  logic [15:0]    hdr_r [5];
  logic [15:0]    hdr_nxt [5];
  logic [15:0]    left_r, left_nxt;
  logic [1:0]     sect_r, sect_nxt;
  logic [2:0]     ph_r, ph_nxt;
  logic [15:0]    skip_r, skip_nxt;
  logic [63:0]    shift_r, shift_nxt;
  logic [3:0]     fcnt_r, fcnt_nxt;
  logic [BPW-1:0] rstart_r, rstart_nxt;
  logic [RSW-1:0] seen_r, seen_nxt;
  logic [1:0]     err_r, err_nxt;

  logic           want_begin, want_start, found;
  logic [2:0]     from_s;
  logic [3:0]     need;
  logic [2:0]     hidx;
  logic [15:0]    rdlen;

  always_comb begin
    bp_nxt = bp_r; left_nxt = left_r; sect_nxt = sect_r; ph_nxt = ph_r;
    skip_nxt = skip_r; shift_nxt = shift_r; fcnt_nxt = fcnt_r;
    rstart_nxt = rstart_r; seen_nxt = seen_r; err_nxt = err_r;
    for (int k = 0; k < 5; k++) hdr_nxt[k] = hdr_r[k];
    want_begin = 1'b0; want_start = 1'b0; found = 1'b0; from_s = 3'd0;
    need = (sect_r == 2'd0) ? Q_FIXED : RR_FIXED;
    hidx = 3'(bp_r[3:1] - 3'd1);
    rdlen = 16'd0;
    wr = '0; rec = '0; frm = '0;

    if (take) begin
      if (ph_nxt != PH_HALT && bp_r >= BPW'(MAX_FRAME_BYTES)) begin
        if (err_nxt == ST_OK) err_nxt = ST_TOOLONG;
        ph_nxt = PH_HALT;
      end
      if (ph_nxt != PH_HALT) begin
        bp_nxt = bp_r + 1'b1;
        case (ph_r)
          PH_HEADER: begin
            if (bp_r >= BPW'(2) && bp_r <= BPW'(HDR_BYTES - 1))
              hdr_nxt[hidx] = {hdr_r[hidx][7:0], item.data_byte};
            if (bp_r >= BPW'(HDR_BYTES - 1)) begin
              want_begin = 1'b1; from_s = 3'd0;
            end
          end
          PH_NAME: begin
            if (item.data_byte == 8'd0) begin
              ph_nxt = PH_FIXED; shift_nxt = '0; fcnt_nxt = '0; skip_nxt = '0;
            end else if (item.data_byte[7:6] == 2'b11) begin
              ph_nxt = PH_POINTER;
            end else begin
              skip_nxt = {8'd0, item.data_byte}; ph_nxt = PH_LABEL;
            end
          end
          PH_LABEL: begin
            skip_nxt = skip_r - 1'b1;
            if (skip_nxt == 16'd0) ph_nxt = PH_NAME;
          end
          PH_POINTER: begin
            ph_nxt = PH_FIXED; shift_nxt = '0; fcnt_nxt = '0; skip_nxt = '0;
          end
          PH_FIXED: begin
            if (fcnt_r < 4'd8) shift_nxt = {shift_r[55:0], item.data_byte};
            else skip_nxt = {skip_r[7:0], item.data_byte};
            fcnt_nxt = fcnt_r + 1'b1;
            if (fcnt_nxt >= need) begin
              wr.rec_vld = 1'b1;
              rec.section = sect_r;
              if (sect_r == 2'd0) begin
                rec.record_type  = shift_nxt[31:16];
                rec.record_class = shift_nxt[15:0];
              end else begin
                rdlen = skip_nxt;
                rec.record_type  = shift_nxt[63:48];
                rec.record_class = shift_nxt[47:32];
                rec.time_to_live = shift_nxt[31:0];
                rec.rdata_length = rdlen;
              end
              rec.name_length   = 12'(bp_nxt) - 12'(need) - 12'(rstart_r);
              rec.record_offset = 12'(rstart_r);
              seen_nxt = seen_r + 1'b1;
              if (rdlen != 16'd0) ph_nxt = PH_RDATA;
              else begin
                left_nxt = left_r - 1'b1;
                if (left_nxt == 16'd0) begin
                  want_begin = 1'b1; from_s = 3'(sect_r) + 3'd1;
                end else want_start = 1'b1;
              end
            end
          end
          PH_RDATA: begin
            skip_nxt = skip_r - 1'b1;
            if (skip_nxt == 16'd0) begin
              left_nxt = left_r - 1'b1;
              if (left_nxt == 16'd0) begin
                want_begin = 1'b1; from_s = 3'(sect_r) + 3'd1;
              end else want_start = 1'b1;
            end
          end
          default: ;
        endcase

        // first non-empty section at or after from_s
        if (want_begin) begin
          for (int s = 0; s < 4; s++) begin
            if (!found && 3'(s) >= from_s && hdr_nxt[s+1] != 16'd0) begin
              found = 1'b1; sect_nxt = 2'(s); left_nxt = hdr_nxt[s+1];
            end
          end
          if (found) want_start = 1'b1;
          else ph_nxt = PH_DONE;
        end
        if (want_start) begin
          if (seen_nxt >= RSW'(MAX_RECORDS)) begin
            err_nxt = ST_RECLIM; ph_nxt = PH_HALT;
          end else begin
            ph_nxt = PH_NAME; rstart_nxt = bp_nxt; skip_nxt = '0;
            shift_nxt = '0; fcnt_nxt = '0;
          end
        end
      end

      if (item.end_of_frame) begin
        wr.frm_vld = 1'b1;
        frm.kind = 1'b1;
        frm.last = 1'b1;
        frm.is_query = ((hdr_nxt[0] & FLAG_RESPONSE) == 16'd0);
        frm.is_truncated = ((hdr_nxt[0] & FLAG_TRUNC) != 16'd0);
        if (err_nxt != ST_OK) frm.status = err_nxt;
        else if (ph_nxt == PH_DONE) frm.status = ST_OK;
        else frm.status = ST_EARLY;
        bp_nxt = '0; left_nxt = '0; sect_nxt = '0; ph_nxt = PH_HEADER;
        skip_nxt = '0; shift_nxt = '0; fcnt_nxt = '0; rstart_nxt = '0;
        seen_nxt = '0; err_nxt = ST_OK;
        for (int k = 0; k < 5; k++) hdr_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= '0; left_r <= '0; sect_r <= '0; ph_r <= PH_HEADER;
      skip_r <= '0; shift_r <= '0; fcnt_r <= '0; rstart_r <= '0;
      seen_r <= '0; err_r <= ST_OK;
      for (int k = 0; k < 5; k++) hdr_r[k] <= '0;
    end else begin
      bp_r <= bp_nxt; left_r <= left_nxt; sect_r <= sect_nxt; ph_r <= ph_nxt;
      skip_r <= skip_nxt; shift_r <= shift_nxt; fcnt_r <= fcnt_nxt;
      rstart_r <= rstart_nxt; seen_r <= seen_nxt; err_r <= err_nxt;
      for (int k = 0; k < 5; k++) hdr_r[k] <= hdr_nxt[k];
    end
  end

endmodule

/* design/dmrw_queue.sv */
// ----------------------------------------------------------------------------
// dmrw_queue
// Back end: result queue taking up to two results per cycle, in order.
// ----------------------------------------------------------------------------
module dmrw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  dmrw_pkg::wr_ctl_t   wr,
  input  dmrw_pkg::out_item_t rec,
  input  dmrw_pkg::out_item_t frm,
  output logic                no_room,
  output logic                empty,
  input  logic                pop,
  output dmrw_pkg::out_item_t head
);
  import dmrw_pkg::*;

  out_item_t  mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign empty   = (cnt_r == 3'd0);
  assign no_room = (cnt_r >= 3'd3);
  assign head    = mem_r[rp_r];
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r + 2'(wr.rec_vld) + 2'(wr.frm_vld);
    rp_nxt  = rp_r + 2'(do_pop);
    cnt_nxt = cnt_r + 3'(wr.rec_vld) + 3'(wr.frm_vld) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (wr.rec_vld) mem_r[wp_r] <= rec;
    if (wr.frm_vld) mem_r[wp_r + 2'(wr.rec_vld)] <= frm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/dns_message_record_walker_top.sv */
// a result is registered in the queue and shows on out_data once at the queue head
// throughput: one byte per cycle while full is low; parser state is registered
// and a frame byte yields at most two results into a four-entry queue
// full rises while fewer than two queue entries are free
// reset: synchronous active-low rst_n clears parser state and the queue
// ----------------------------------------------------------------------------
// dns_message_record_walker_top
// Walks DNS message records byte by byte and reports record and frame results.
// ----------------------------------------------------------------------------
module dns_message_record_walker_top #(
  parameter int MAX_FRAME_BYTES = 4096,
  parameter int MAX_RECORDS     = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  dmrw_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output dmrw_pkg::out_item_t out_data
);
  import dmrw_pkg::*;

  wr_ctl_t   wr;
  out_item_t rec, frm;
  logic      no_room;

  // byte transfer when the queue can absorb both possible results
  assign full = no_room;

  // front: header capture, label skipping, fixed-field assembly
  dmrw_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .MAX_RECORDS(MAX_RECORDS)
  ) u_parser (
    .clk(clk), .rst_n(rst_n), .take(push && !no_room), .item(in_data),
    .wr(wr), .rec(rec), .frm(frm)
  );

  // back: ordered result queue toward the consumer
  dmrw_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(wr), .rec(rec), .frm(frm),
    .no_room(no_room), .empty(empty), .pop(pop), .head(out_data)
  );

endmodule

/* bench/dns_message_record_walker_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_message_record_walker_top_test
// Feeds whole and broken DNS messages byte by byte and checks every record
// and frame summary against a cycle-free model of the walker.
// ----------------------------------------------------------------------------
module dns_message_record_walker_top_test;
  import dmrw_pkg::*;

  localparam int FRAME_LIMIT = 4096;
  localparam int RECORD_LIMIT = 128;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_item_t in_data = '0;
  out_item_t out_data;

  dns_message_record_walker_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // bytes waiting to go in, summaries waiting to come out
  in_item_t message_bytes[$];
  out_item_t expected_summaries[$];
  int bytes_taken = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // walker model state
  int pos_count;
  logic [15:0] hdr_words[5];
  int left_in_section;
  int cur_section;
  logic [2:0] phase;
  int skip_count;
  logic [63:0] fixed_shift;
  int fixed_count;
  int rec_start;
  int rec_seen;
  logic [1:0] err_code;

  function automatic void clear_walker();
    pos_count = 0;
    foreach (hdr_words[i]) hdr_words[i] = '0;
    left_in_section = 0;
    cur_section = 0;
    phase = PH_HEADER;
    skip_count = 0;
    fixed_shift = '0;
    fixed_count = 0;
    rec_start = 0;
    rec_seen = 0;
    err_code = ST_OK;
  endfunction

  function automatic void open_record();
    if (rec_seen >= RECORD_LIMIT) begin
      err_code = ST_RECLIM;
      phase = PH_HALT;
    end else begin
      phase = PH_NAME;
      rec_start = pos_count;
      skip_count = 0;
      fixed_shift = '0;
      fixed_count = 0;
    end
  endfunction

  // first section from s on with a nonzero count, else done
  function automatic void open_section(int s);
    while (s < 4) begin
      if (hdr_words[1 + s] != 0) begin
        cur_section = s;
        left_in_section = hdr_words[1 + s];
        open_record();
        return;
      end
      s++;
    end
    phase = PH_DONE;
  endfunction

  function automatic void close_record();
    left_in_section = (left_in_section - 1) & 16'hffff;
    if (left_in_section == 0) open_section(cur_section + 1);
    else open_record();
  endfunction

  function automatic void start_fixed();
    phase = PH_FIXED;
    fixed_shift = '0;
    fixed_count = 0;
    skip_count = 0;
  endfunction

  // advance the walker by one byte and queue what it reports
  function automatic void walk_byte(in_item_t it);
    int p;
    int need;
    int rdlen;
    out_item_t r;
    if (phase != PH_HALT && pos_count >= FRAME_LIMIT) begin
      if (err_code == ST_OK) err_code = ST_TOOLONG;
      phase = PH_HALT;
    end
    if (phase != PH_HALT) begin
      p = pos_count;
      pos_count++;
      case (phase)
        PH_HEADER: begin
          if (p >= 2 && p <= 11)
            hdr_words[(p >> 1) - 1] = {hdr_words[(p >> 1) - 1][7:0], it.data_byte};
          if (p >= HDR_BYTES - 1) open_section(0);
        end
        PH_NAME: begin
          if (it.data_byte == 0) start_fixed();
          else if (it.data_byte[7:6] == 2'b11) phase = PH_POINTER;
          else begin
            skip_count = it.data_byte;
            phase = PH_LABEL;
          end
        end
        PH_LABEL: begin
          skip_count--;
          if (skip_count == 0) phase = PH_NAME;
        end
        PH_POINTER: start_fixed();
        PH_FIXED: begin
          need = (cur_section == 0) ? Q_FIXED : RR_FIXED;
          if (fixed_count < 8) fixed_shift = {fixed_shift[55:0], it.data_byte};
          else skip_count = ((skip_count << 8) | it.data_byte) & 16'hffff;
          fixed_count++;
          if (fixed_count >= need) begin
            r = '0;
            rdlen = 0;
            r.section = cur_section[1:0];
            if (cur_section == 0) begin
              r.record_type = fixed_shift[31:16];
              r.record_class = fixed_shift[15:0];
            end else begin
              rdlen = skip_count;
              r.record_type = fixed_shift[63:48];
              r.record_class = fixed_shift[47:32];
              r.time_to_live = fixed_shift[31:0];
              r.rdata_length = rdlen[15:0];
            end
            r.name_length = 12'(p + 1 - need - rec_start);
            r.record_offset = 12'(rec_start);
            expected_summaries.push_back(r);
            rec_seen++;
            if (rdlen != 0) phase = PH_RDATA;
            else close_record();
          end
        end
        PH_RDATA: begin
          skip_count--;
          if (skip_count == 0) close_record();
        end
        default: ;
      endcase
    end
    if (it.end_of_frame) begin
      r = '0;
      r.kind = 1'b1;
      if (err_code != ST_OK) r.status = err_code;
      else if (phase == PH_DONE) r.status = ST_OK;
      else r.status = ST_EARLY;
      r.is_query = (hdr_words[0] & FLAG_RESPONSE) == 0;
      r.is_truncated = (hdr_words[0] & FLAG_TRUNC) != 0;
      r.last = 1'b1;
      expected_summaries.push_back(r);
      clear_walker();
    end
  endfunction

  // idling profile moves through its phases as bytes go in
  int idle_phase;
  int send_idle_pct;
  int recv_stall_pct;
  always_comb begin
    idle_phase = (bytes_taken / 225) % 4;
    send_idle_pct = (idle_phase == 1 || idle_phase == 3) ? 46 : 0;
    recv_stall_pct = (idle_phase == 2 || idle_phase == 3) ? 46 : 0;
    if (idle_phase == 3) begin
      send_idle_pct = 9;
      recv_stall_pct = 9;
    end
  end

  // driver: offer the head byte or idle, change inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (message_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        in_data <= message_bytes[0];
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: byte transfers feed the model, result transfers get checked
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (push && !full) begin
        walk_byte(in_data);
        void'(message_bytes.pop_front());
        bytes_taken++;
      end
      if (pop && !empty) begin
        if (expected_summaries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_summaries.pop_front();
          if (out_data.kind !== want.kind || out_data.section !== want.section ||
              out_data.record_type !== want.record_type ||
              out_data.record_class !== want.record_class ||
              out_data.time_to_live !== want.time_to_live ||
              out_data.rdata_length !== want.rdata_length ||
              out_data.name_length !== want.name_length ||
              out_data.record_offset !== want.record_offset ||
              out_data.is_query !== want.is_query ||
              out_data.is_truncated !== want.is_truncated ||
              out_data.status !== want.status || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      // watchdog on cycles with no transfer at all while work is pending
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else if (message_bytes.size() > 0 || expected_summaries.size() > 0)
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("dns_message_record_walker_top_test failed");
        $finish;
      end
    end
  end

  // message building
  logic [7:0] frame_buf[$];

  task automatic put_frame(int cut);
    int n;
    n = (cut > 0 && cut < frame_buf.size()) ? cut : frame_buf.size();
    for (int i = 0; i < n; i++) message_bytes.push_back({frame_buf[i], i == n - 1});
    frame_buf.delete();
  endtask

  task automatic add_header(logic [15:0] flags, int qd, int an, int ns, int ar);
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(flags[15:8]);
    frame_buf.push_back(flags[7:0]);
    frame_buf.push_back(8'(qd >> 8)); frame_buf.push_back(8'(qd));
    frame_buf.push_back(8'(an >> 8)); frame_buf.push_back(8'(an));
    frame_buf.push_back(8'(ns >> 8)); frame_buf.push_back(8'(ns));
    frame_buf.push_back(8'(ar >> 8)); frame_buf.push_back(8'(ar));
  endtask

  // owner name: labels ending in a root byte or a compression pointer
  task automatic add_name(int labels, bit wide_label, bit use_pointer);
    int len;
    for (int l = 0; l < labels; l++) begin
      len = wide_label ? $urandom_range(8'h40, 8'h48) : $urandom_range(1, 5);
      frame_buf.push_back(8'(len));
      repeat (len) frame_buf.push_back(8'($urandom));
    end
    if (use_pointer) begin
      frame_buf.push_back(8'hc0 | 8'($urandom_range(63)));
      frame_buf.push_back(8'($urandom));
    end else begin
      frame_buf.push_back(8'h00);
    end
  endtask

  task automatic add_record(bit question, int rdlen);
    add_name($urandom_range(3), $urandom_range(15) == 0, 1'($urandom_range(1)));
    repeat (question ? 4 : 8) frame_buf.push_back(8'($urandom));
    if (!question) begin
      frame_buf.push_back(8'(rdlen >> 8));
      frame_buf.push_back(8'(rdlen));
      repeat (rdlen) frame_buf.push_back(8'($urandom));
    end
  endtask

  task automatic build_message(int qd, int an, int ns, int ar, int trailing);
    add_header(16'($urandom), qd, an, ns, ar);
    repeat (qd) add_record(1'b1, 0);
    repeat (an + ns + ar) add_record(1'b0, $urandom_range(4));
    repeat (trailing) frame_buf.push_back(8'($urandom));
  endtask

  initial begin
    int cut;
    clear_walker();
    // directed: short header, extremes, empty sections, pointers, trailing bytes
    add_header(16'h0000, 0, 0, 0, 0);
    put_frame(5);
    add_header(16'h8200, 0, 0, 0, 0);
    put_frame(0);
    add_header(16'hffff, 1, 1, 0, 1);
    add_name(1, 1'b0, 1'b1);
    frame_buf.push_back(8'hff); frame_buf.push_back(8'hff);
    frame_buf.push_back(8'h00); frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    repeat (4) frame_buf.push_back(8'hff);
    repeat (4) frame_buf.push_back(8'hff);
    frame_buf.push_back(8'h00); frame_buf.push_back(8'h01); frame_buf.push_back(8'hab);
    add_name(1, 1'b1, 1'b0);
    repeat (8) frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00); frame_buf.push_back(8'h00);
    repeat (3) frame_buf.push_back(8'($urandom));
    put_frame(0);
    build_message(0, 0, 2, 0, 0);
    put_frame(0);
    // record limit: more questions than the walker may report
    add_header(16'h0100, RECORD_LIMIT + 2, 0, 0, 0);
    repeat (RECORD_LIMIT + 2) begin
      frame_buf.push_back(8'h00);
      repeat (4) frame_buf.push_back(8'($urandom));
    end
    put_frame(0);
    // random messages: mostly well formed, some cut short, some noise
    while (message_bytes.size() + bytes_taken < 900) begin
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom));
          put_frame(0);
        end
        1, 2: begin
          build_message($urandom_range(3), $urandom_range(3), $urandom_range(2),
                        $urandom_range(2), 0);
          cut = $urandom_range(1, frame_buf.size());
          put_frame(cut);
        end
        default: begin
          build_message($urandom_range(3), $urandom_range(3), $urandom_range(2),
                        $urandom_range(2), ($urandom_range(3) == 0) ? $urandom_range(4) : 0);
          put_frame(0);
        end
      endcase
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (message_bytes.size() == 0 && expected_summaries.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_summaries.size() == 0) begin
      $display("dns_message_record_walker_top_test passed");
    end else begin
      $display("dns_message_record_walker_top_test failed");
    end
    $finish;
  end

endmodule

/* dns_message_record_walker_top.f */
design/dmrw_pkg.sv
design/dmrw_parser.sv
design/dmrw_queue.sv
design/dns_message_record_walker_top.sv
bench/dns_message_record_walker_top_test.sv
